[rtl/assert_macros.svh]
// Assertion macros shared by the colormap RTL.
// Clocked on i_clk; one form is gated by the active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: property failed");

// Check a property at every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("%m: property failed");

`endif

[rtl/pwlc_pkg.sv]
// Package for the piecewise linear colormap: fixed-point sizes,
// register indexes and register reset values. No dependencies.
package pwlc_pkg;

    localparam int MAX_STOPS = 8;
    localparam int FRAC_BITS = 16;

    localparam int VALUE_W   = 18;
    localparam int CHAN_W    = 8;
    localparam int STOP_W    = 4 * CHAN_W;
    localparam int PAIR_W    = 2 * STOP_W;
    localparam int NUM_PAIRS = MAX_STOPS / 2;
    localparam int COUNT_W   = 4;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;
    localparam int IDX_W     = ADDR_W - 3;

    localparam int V_W   = FRAC_BITS + 1;
    localparam int SEG_W = $clog2(MAX_STOPS);
    localparam int S_W   = V_W + SEG_W;
    localparam int P_W   = CHAN_W + V_W;
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int HALF  = ONE / 2;

    localparam logic [COUNT_W-1:0] STOP_COUNT_RST = COUNT_W'(2);
    localparam logic [PAIR_W-1:0]  PAIR0_RST      = 64'hFFFF_FFFF_0000_00FF;

    typedef enum logic [IDX_W-1:0] {
        REG_STOP_COUNT = 3'd0,
        REG_STOP_PAIR0 = 3'd1,
        REG_STOP_PAIR1 = 3'd2,
        REG_STOP_PAIR2 = 3'd3,
        REG_STOP_PAIR3 = 3'd4
    } t_reg_idx;

endpackage

[rtl/piecewise_linear_colormap.sv]
// Piecewise linear colormap: five-stage pipeline and APB register file.
// Depends on pwlc_pkg and assert_macros.svh.
//
// Usage:
// - Input channel: i_valid / i_value, with o_stall back to the sender. A beat
//   is taken at a rising edge with i_valid high and o_stall low.
// - Output channel: o_valid / o_red, o_green, o_blue, o_alpha, with i_stall
//   from the receiver. One result beat per input beat, in order.
// - Registers at byte address 8*i: stop_count, then stop_pair_0..3 (64 bits).
//   Write them only while no beat is in flight.
// - Stages, in order: clamp, multiply by
//   stop_count-1, pick the two stops, channel products, sum and round.
// - Throughput: one beat per cycle while the receiver does not stall a result.
// - When the receiver stalls with a result waiting, the whole pipeline holds
//   and o_stall rises; earlier bubbles do not collapse.
// - Reset (synchronous, active low) empties the pipeline and restores a
//   two-stop gradient from opaque black to opaque white.
`include "assert_macros.svh"

module piecewise_linear_colormap
    import pwlc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_stall,
    output logic                      o_valid,
    output logic        [CHAN_W-1:0]  o_red,
    output logic        [CHAN_W-1:0]  o_green,
    output logic        [CHAN_W-1:0]  o_blue,
    output logic        [CHAN_W-1:0]  o_alpha,
    input  logic                      i_stall,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic        [ADDR_W-1:0]  paddr,
    input  logic        [DATA_W-1:0]  pwdata,
    output logic        [DATA_W-1:0]  prdata,
    output logic                      pready
);

    logic [COUNT_W-1:0] r_stop_count;
    logic [PAIR_W-1:0]  r_pair [NUM_PAIRS];
    t_reg_idx           w_idx;
    logic               w_wr;

    logic w_adv;
    logic w_in_acc;

    logic             r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [V_W-1:0]   r_val1;
    logic [V_W-1:0]   n_val1;
    logic [V_W-1:0]   w_mag;
    logic [SEG_W-1:0] w_nm1;
    logic [S_W-1:0]   w_s;
    logic [SEG_W-1:0] n_seg2, r_seg2;
    logic [V_W-1:0]   n_frac2, r_frac2, r_frac3;
    logic [STOP_W-1:0] w_stop [MAX_STOPS];
    logic [PAIR_W-1:0] w_win  [MAX_STOPS-1];
    logic [PAIR_W-1:0] r_win3;
    logic [P_W-1:0]    r_pa4 [4];
    logic [P_W-1:0]    r_pb4 [4];
    logic [CHAN_W-1:0] r_out5 [4];

    // register file
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= STOP_COUNT_RST;
            r_pair[0]    <= PAIR0_RST;
            for (int k = 1; k < NUM_PAIRS; k++) begin
                r_pair[k] <= '0;
            end
        end else if (w_wr) begin
            case (w_idx)
                REG_STOP_COUNT: r_stop_count <= pwdata[COUNT_W-1:0];
                REG_STOP_PAIR0: r_pair[0]    <= pwdata;
                REG_STOP_PAIR1: r_pair[1]    <= pwdata;
                REG_STOP_PAIR2: r_pair[2]    <= pwdata;
                REG_STOP_PAIR3: r_pair[3]    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_STOP_COUNT: prdata = DATA_W'(r_stop_count);
            REG_STOP_PAIR0: prdata = r_pair[0];
            REG_STOP_PAIR1: prdata = r_pair[1];
            REG_STOP_PAIR2: prdata = r_pair[2];
            REG_STOP_PAIR3: prdata = r_pair[3];
            default:        prdata = '0;
        endcase
    end

    // handshake: hold everything while a result waits on a stalled receiver
    assign w_adv    = !(r_v5 && i_stall);
    assign o_stall  = !w_adv;
    assign w_in_acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: clamp to 0..ONE
    assign w_mag = V_W'(i_value[VALUE_W-2:0]);
    always_comb begin
        if (i_value[VALUE_W-1]) begin
            n_val1 = '0;
        end else if (w_mag > V_W'(ONE)) begin
            n_val1 = V_W'(ONE);
        end else begin
            n_val1 = w_mag;
        end
    end

    // stage 2: scale by stop_count-1, split segment and fraction
    always_comb begin
        if (r_stop_count < COUNT_W'(2)) begin
            w_nm1 = SEG_W'(1);
        end else if (r_stop_count > COUNT_W'(MAX_STOPS)) begin
            w_nm1 = SEG_W'(MAX_STOPS - 1);
        end else begin
            w_nm1 = SEG_W'(r_stop_count - COUNT_W'(1));
        end
    end

    assign w_s = S_W'(r_val1) * S_W'(w_nm1);

    always_comb begin
        if (w_s[S_W-1:FRAC_BITS] >= w_nm1) begin
            n_seg2  = w_nm1 - SEG_W'(1);
            n_frac2 = V_W'(ONE);
        end else begin
            n_seg2  = w_s[FRAC_BITS +: SEG_W];
            n_frac2 = V_W'(w_s[FRAC_BITS-1:0]);
        end
    end

    // stage 3: each segment's stop pair sits at a fixed place
    for (genvar k = 0; k < MAX_STOPS; k++) begin : g_stop
        assign w_stop[k] = r_pair[k/2][STOP_W*(k%2) +: STOP_W];
    end
    for (genvar k = 0; k < MAX_STOPS - 1; k++) begin : g_win
        assign w_win[k] = {w_stop[k+1], w_stop[k]};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_val1  <= n_val1;
            r_seg2  <= n_seg2;
            r_frac2 <= n_frac2;
            r_win3  <= w_win[r_seg2];
            r_frac3 <= r_frac2;
            // stage 4: weight both ends of every channel
            for (int c = 0; c < 4; c++) begin
                r_pa4[c] <= P_W'(r_win3[STOP_W-CHAN_W*(c+1) +: CHAN_W])
                            * P_W'(V_W'(ONE) - r_frac3);
                r_pb4[c] <= P_W'(r_win3[PAIR_W-CHAN_W*(c+1) +: CHAN_W])
                            * P_W'(r_frac3);
            end
            // stage 5: sum and round half up
            for (int c = 0; c < 4; c++) begin
                r_out5[c] <= CHAN_W'((r_pa4[c] + r_pb4[c] + P_W'(HALF)) >> FRAC_BITS);
            end
        end
    end

    assign o_valid = r_v5;
    assign o_red   = r_out5[0];
    assign o_green = r_out5[1];
    assign o_blue  = r_out5[2];
    assign o_alpha = r_out5[3];

    `ASSERT_CLK(a_full_frac_last_seg, r_v2 && r_frac2[FRAC_BITS] |-> (r_frac2[FRAC_BITS-1:0] == '0) && (r_seg2 == w_nm1 - SEG_W'(1)))
    `ASSERT_CLK(a_beat_reaches_out, w_in_acc ##1 w_adv ##1 w_adv ##1 w_adv ##1 w_adv |=> o_valid)
    `ASSERT_CLK_ALWAYS(a_stall_needs_result, o_stall |-> o_valid)

endmodule
